// ===== hw/rtl/identifier_text_classifier_macros.svh =====
// Assertion macros used by the classifier back end.
`ifndef IDENTIFIER_TEXT_CLASSIFIER_MACROS_SVH
`define IDENTIFIER_TEXT_CLASSIFIER_MACROS_SVH

// Asserts that an antecedent implies a consequent in the same cycle.
`define ITC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Asserts that an antecedent implies a consequent in the next cycle.
`define ITC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/itc_pkg.sv =====
package itc_pkg;

    localparam int unsigned QueueDepth = 3;

    typedef enum logic [3:0] {
        KIND_EMPTY   = 4'd0,
        KIND_NULL    = 4'd1,
        KIND_DECIMAL = 4'd2,
        KIND_UUID    = 4'd3,
        KIND_UUID_UC = 4'd4,
        KIND_PREF    = 4'd5,
        KIND_B64     = 4'd6,
        KIND_HEX     = 4'd7,
        KIND_SHORT   = 4'd8,
        KIND_LONG    = 4'd9
    } kind_t;

    localparam logic [1:0] CASE_UNKNOWN = 2'd0;
    localparam logic [1:0] CASE_LOWER   = 2'd1;
    localparam logic [1:0] CASE_UPPER   = 2'd2;

    localparam logic [3:0] REQ_ANY = 4'd0;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       has_byte;
        logic       last;
        logic [3:0] requested_kind;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  id_kind;
        logic [63:0] value_high;
        logic [63:0] value_low;
        logic        kind_error;
    } out_item_t;

    // Result of the last byte, held between the front and the back.
    typedef struct packed {
        logic [5:0]   len;
        logic [3:0]   req;
        logic [6:0]   flags;
        logic [1:0]   lcase;
        logic [127:0] hex_val;
        logic [127:0] dec_val;
        logic [127:0] pref_val;
        logic [127:0] b64_val;
    } summary_t;

    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b0, b[3:0]};
        else if (b >= 8'h61 && b <= 8'h66) r = 5'(b - 8'h57);
        else if (b >= 8'h41 && b <= 8'h46) r = 5'(b - 8'h37);
        return r;
    endfunction

    function automatic logic [6:0] url_b64(input logic [7:0] b);
        logic [6:0] r;
        r = 7'h40;
        if (b >= 8'h30 && b <= 8'h39) r = 7'(b - 8'h30);
        else if (b >= 8'h41 && b <= 8'h5A) r = 7'(b - 8'h37);
        else if (b >= 8'h61 && b <= 8'h7A) r = 7'(b - 8'h3D);
        else if (b == 8'h2D) r = 7'd62;
        else if (b == 8'h5F) r = 7'd63;
        return r;
    endfunction

    function automatic logic [6:0] sort_b64(input logic [7:0] b);
        logic [6:0] r;
        r = 7'h40;
        if (b == 8'h2B) r = 7'd0;
        else if (b == 8'h2F) r = 7'd1;
        else if (b >= 8'h30 && b <= 8'h39) r = 7'(b - 8'h2E);
        else if (b >= 8'h41 && b <= 8'h5A) r = 7'(b - 8'h35);
        else if (b >= 8'h61 && b <= 8'h7A) r = 7'(b - 8'h3B);
        return r;
    endfunction

endpackage

// ===== hw/rtl/itc_stream_if.sv =====
interface itc_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/itc_front.sv =====
module itc_front (
    input  logic               clk,
    input  logic               rst_n,
    itc_stream_if.sink         in_ch,
    output logic               sum_valid,
    output itc_pkg::summary_t  sum_data,
    input  logic               sum_ready
);
    import itc_pkg::*;

    logic [5:0]   cnt_reg, cnt_next;
    logic [127:0] hex_reg, hex_next, dec_reg, dec_next;
    logic [127:0] pref_reg, pref_next, b64_reg, b64_next;
    logic [6:0]   flags_reg, flags_next;
    logic [1:0]   lcase_reg, lcase_next;
    logic [3:0]   req_reg, req_next;
    logic         take, step, fin;
    logic [7:0]   b;
    logic [4:0]   h;
    logic [6:0]   u, s;
    logic [127:0] dec_sum;

    assign b    = in_ch.payload.byte_in;
    assign take = in_ch.valid && in_ch.ready;
    assign step = take && (in_ch.payload.has_byte || in_ch.payload.last);
    assign fin  = take && in_ch.payload.last;
    assign in_ch.ready = sum_ready;
    assign h = hex_digit(b);
    assign u = url_b64(b);
    assign s = sort_b64(b);
    assign dec_sum = (dec_reg << 3) + (dec_reg << 1) + 128'(b[3:0]);

    always_comb
    begin
        cnt_next   = cnt_reg;
        hex_next   = hex_reg;
        dec_next   = dec_reg;
        pref_next  = pref_reg;
        b64_next   = b64_reg;
        flags_next = flags_reg;
        lcase_next = lcase_reg;
        req_next   = req_reg;
        if (step && cnt_reg == 6'd0)
        begin
            req_next = in_ch.payload.requested_kind;
        end
        if (step && in_ch.payload.has_byte)
        begin
            case (cnt_reg)
                6'd0: if (b != 8'h6E) flags_next[0] = 1'b0;
                6'd1: if (b != 8'h75) flags_next[0] = 1'b0;
                6'd2, 6'd3: if (b != 8'h6C) flags_next[0] = 1'b0;
                default: ;
            endcase
            if (cnt_reg == 6'd0 && b != 8'h30) flags_next[1] = 1'b0;
            if (cnt_reg == 6'd8 || cnt_reg == 6'd13 || cnt_reg == 6'd18
                || cnt_reg == 6'd23)
            begin
                if (b != 8'h2D) flags_next[2] = 1'b0;
            end
            else if (h[4])
            begin
                flags_next[2] = 1'b0;
            end
            else if (b >= 8'h61 && b <= 8'h66)
            begin
                if (lcase_reg == CASE_UPPER) flags_next[2] = 1'b0;
                else lcase_next = CASE_LOWER;
            end
            else if (b >= 8'h41 && b <= 8'h46)
            begin
                if (lcase_reg == CASE_LOWER) flags_next[2] = 1'b0;
                else lcase_next = CASE_UPPER;
            end
            if (h[4]) flags_next[6] = 1'b0;
            else hex_next = {hex_reg[123:0], h[3:0]};
            case (cnt_reg)
                6'd0: if (b != 8'h43) flags_next[3] = 1'b0;
                6'd1: if (b != 8'h41) flags_next[3] = 1'b0;
                6'd2, 6'd4: if (b != 8'h45) flags_next[3] = 1'b0;
                6'd3: if (b != 8'h53) flags_next[3] = 1'b0;
                default:
                begin
                    if (u[6]) flags_next[3] = 1'b0;
                    else pref_next = {pref_reg[121:0], u[5:0]};
                end
            endcase
            if (b < 8'h30 || b > 8'h39 || (cnt_reg == 6'd0 && b == 8'h30))
                flags_next[4] = 1'b0;
            else
                dec_next = dec_sum;
            if (s[6]) flags_next[5] = 1'b0;
            else b64_next = {b64_reg[121:0], s[5:0]};
            if (cnt_reg != 6'd63) cnt_next = cnt_reg + 6'd1;
        end
        if (fin)
        begin
            cnt_next   = '0;
            hex_next   = '0;
            dec_next   = '0;
            pref_next  = '0;
            b64_next   = '0;
            flags_next = '1;
            lcase_next = CASE_UNKNOWN;
            req_next   = REQ_ANY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            hex_reg   <= '0;
            dec_reg   <= '0;
            pref_reg  <= '0;
            b64_reg   <= '0;
            flags_reg <= '1;
            lcase_reg <= CASE_UNKNOWN;
            req_reg   <= REQ_ANY;
            sum_valid <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            hex_reg   <= hex_next;
            dec_reg   <= dec_next;
            pref_reg  <= pref_next;
            b64_reg   <= b64_next;
            flags_reg <= flags_next;
            lcase_reg <= lcase_next;
            req_reg   <= req_next;
            sum_valid <= fin;
        end
    end

    // The clearing on a last item hides the updated values, so they are
    // recomputed here from the same inputs.
    function automatic logic [6:0] flags_next_keep();
        logic [6:0] f;
        f = flags_reg;
        if (in_ch.payload.has_byte)
        begin
            if (cnt_reg < 6'd4)
            begin
                case (cnt_reg)
                    6'd0: if (b != 8'h6E) f[0] = 1'b0;
                    6'd1: if (b != 8'h75) f[0] = 1'b0;
                    default: if (b != 8'h6C) f[0] = 1'b0;
                endcase
            end
            if (cnt_reg == 6'd0 && b != 8'h30) f[1] = 1'b0;
            if (cnt_reg == 6'd8 || cnt_reg == 6'd13 || cnt_reg == 6'd18
                || cnt_reg == 6'd23)
            begin
                if (b != 8'h2D) f[2] = 1'b0;
            end
            else if (h[4]) f[2] = 1'b0;
            else if (b >= 8'h61 && b <= 8'h66 && lcase_reg == CASE_UPPER) f[2] = 1'b0;
            else if (b >= 8'h41 && b <= 8'h46 && lcase_reg == CASE_LOWER) f[2] = 1'b0;
            if (h[4]) f[6] = 1'b0;
            case (cnt_reg)
                6'd0: if (b != 8'h43) f[3] = 1'b0;
                6'd1: if (b != 8'h41) f[3] = 1'b0;
                6'd2, 6'd4: if (b != 8'h45) f[3] = 1'b0;
                6'd3: if (b != 8'h53) f[3] = 1'b0;
                default: if (u[6]) f[3] = 1'b0;
            endcase
            if (b < 8'h30 || b > 8'h39 || (cnt_reg == 6'd0 && b == 8'h30)) f[4] = 1'b0;
            if (s[6]) f[5] = 1'b0;
        end
        return f;
    endfunction

    function automatic logic [1:0] lcase_next_keep();
        logic [1:0] c;
        logic       sep;
        c = lcase_reg;
        sep = (cnt_reg == 6'd8 || cnt_reg == 6'd13 || cnt_reg == 6'd18
               || cnt_reg == 6'd23);
        if (in_ch.payload.has_byte && !sep && !h[4])
        begin
            if (b >= 8'h61 && b <= 8'h66 && lcase_reg != CASE_UPPER) c = CASE_LOWER;
            if (b >= 8'h41 && b <= 8'h46 && lcase_reg != CASE_LOWER) c = CASE_UPPER;
        end
        return c;
    endfunction

    function automatic logic [127:0] hex_keep();
        return (in_ch.payload.has_byte && !h[4]) ? {hex_reg[123:0], h[3:0]} : hex_reg;
    endfunction

    function automatic logic [127:0] dec_keep();
        return (in_ch.payload.has_byte && b >= 8'h30 && b <= 8'h39
                && !(cnt_reg == 6'd0 && b == 8'h30)) ? dec_sum : dec_reg;
    endfunction

    function automatic logic [127:0] pref_keep();
        return (in_ch.payload.has_byte && cnt_reg >= 6'd5 && !u[6])
               ? {pref_reg[121:0], u[5:0]} : pref_reg;
    endfunction

    function automatic logic [127:0] b64_keep();
        return (in_ch.payload.has_byte && !s[6]) ? {b64_reg[121:0], s[5:0]} : b64_reg;
    endfunction

    // Snapshot of the finished string, registered when its last byte is taken.
    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            sum_data.len      <= (in_ch.payload.has_byte && cnt_reg != 6'd63)
                                 ? cnt_reg + 6'd1 : cnt_reg;
            sum_data.req      <= (cnt_reg == 6'd0) ? in_ch.payload.requested_kind
                                                   : req_reg;
            sum_data.flags    <= flags_next_keep();
            sum_data.lcase    <= lcase_next_keep();
            sum_data.hex_val  <= hex_keep();
            sum_data.dec_val  <= dec_keep();
            sum_data.pref_val <= pref_keep();
            sum_data.b64_val  <= b64_keep();
        end
    end

endmodule

// ===== hw/rtl/itc_back.sv =====
module itc_back #(
    parameter int unsigned Depth = itc_pkg::QueueDepth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               sum_valid,
    input  itc_pkg::summary_t  sum_data,
    output logic               sum_ready,
    itc_stream_if.source       out_ch
);
    import itc_pkg::*;

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    out_item_t        q_mem [Depth];
    logic [AW-1:0]    wr_reg, rd_reg;
    logic [AW:0]      cnt_reg;
    out_item_t        res;
    logic             push, pop;
    logic [3:0]       req;
    logic [5:0]       len;
    logic [6:0]       f;

    function automatic logic allows(input logic [3:0] r, input logic [3:0] k);
        return r == REQ_ANY || r == k + 4'd1;
    endfunction

    assign req = sum_data.req;
    assign len = sum_data.len;
    assign f   = sum_data.flags;

    always_comb
    begin
        res = '0;
        if (allows(req, KIND_EMPTY) && len == 6'd0)
            res.id_kind = KIND_EMPTY;
        else if (allows(req, KIND_NULL) && len == 6'd4 && f[0])
            res.id_kind = KIND_NULL;
        else if (allows(req, KIND_DECIMAL) && len == 6'd1 && f[1])
            res.id_kind = KIND_DECIMAL;
        else if ((allows(req, KIND_UUID) || allows(req, KIND_UUID_UC))
                 && len == 6'd36 && f[2])
        begin
            res.id_kind = (sum_data.lcase == CASE_UPPER) ? KIND_UUID_UC : KIND_UUID;
            {res.value_high, res.value_low} = sum_data.hex_val;
        end
        else if (allows(req, KIND_PREF) && len == 6'd26 && f[3])
        begin
            res.id_kind = KIND_PREF;
            {res.value_high, res.value_low} = sum_data.pref_val;
        end
        else if (allows(req, KIND_DECIMAL) && len < 6'd40 && f[4])
        begin
            res.id_kind = KIND_DECIMAL;
            {res.value_high, res.value_low} = sum_data.dec_val;
        end
        else if (allows(req, KIND_B64) && len == 6'd16 && f[5])
        begin
            res.id_kind = KIND_B64;
            {res.value_high, res.value_low} = sum_data.b64_val;
        end
        else if (allows(req, KIND_HEX) && len == 6'd32 && f[6])
        begin
            res.id_kind = KIND_HEX;
            {res.value_high, res.value_low} = sum_data.hex_val;
        end
        else
            res.id_kind = (len <= 6'd16) ? KIND_SHORT : KIND_LONG;
        res.kind_error = (req != REQ_ANY) && (res.id_kind + 4'd1 != req);
    end

    // One slot is kept free for the summary already in flight.
    assign sum_ready = cnt_reg < (AW+1)'(Depth - 1);
    assign push = sum_valid;
    assign pop  = out_ch.valid && out_ch.ready;
    assign out_ch.valid   = cnt_reg != '0;
    assign out_ch.payload = q_mem[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push) q_mem[wr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= (wr_reg == AW'(Depth - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)  rd_reg <= (rd_reg == AW'(Depth - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

`include "identifier_text_classifier_macros.svh"
    `ITC_ASSERT_IMP(a_no_overflow, push, cnt_reg < (AW+1)'(Depth))
    `ITC_ASSERT_IMP(a_no_underflow, pop, cnt_reg != '0)
    `ITC_ASSERT_NEXT(a_count_hold, !push && !pop, $stable(cnt_reg))
endmodule

// ===== hw/rtl/identifier_text_classifier.sv =====
// Identifier text classifier.
// The in channel takes one character per request: byte_in, has_byte, last
// and requested_kind. The request code is sampled on the first request of
// each string. A request with has_byte low and last low is ignored.
// On a request with last high, one result appears on the out channel with
// id_kind, a 128-bit value split into value_high and value_low, and
// kind_error. It is registered in the front summary and then in the result queue.
// Throughput is one character per cycle while in.ready is high; the candidate
// decoders update in the cycle a character is taken, and selection happens in
// the back end. A three-entry result queue parts the two sides; when the
// receiver stalls, the queue fills and in.ready drops once two results wait,
// since one more may already be on its way from the front.
// Reset clears all decoder state and empties the queue.
// Strings longer than 62 characters are always long text.
module identifier_text_classifier #(
    parameter int unsigned QueueDepth = itc_pkg::QueueDepth
) (
    input logic          clk,
    input logic          rst_n,
    itc_stream_if.sink   in_ch,
    itc_stream_if.source out_ch
);
    import itc_pkg::*;

    logic     sum_valid, sum_ready;
    summary_t sum_data;

    itc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .sum_valid (sum_valid),
        .sum_data  (sum_data),
        .sum_ready (sum_ready)
    );

    itc_back #(.Depth(QueueDepth)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (sum_valid),
        .sum_data  (sum_data),
        .sum_ready (sum_ready),
        .out_ch    (out_ch)
    );
endmodule
